[rtl/core/arwl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Sharded reader-writer lock package
// Shared types, codes and constants of the lock controller and datapath.
// ---------------------------------------------------------------------------
package arwl_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int WORD_W  = 32;
  localparam int SUM_W   = WORD_W + SLOT_W;
  localparam int TOTAL_W = SUM_W + 1;
  localparam int EXCL_PROD_W = SUM_W + 8;
  localparam int CALM_PROD_W = WORD_W + 10;
  localparam int BUSY_PROD_W = WORD_W + 8;

  localparam logic [WORD_W-1:0] EXCL_MARK = 32'h8000_0000;

  localparam logic [31:0] MIN_SAMPLES_RST     = 32'd1000;
  localparam logic [7:0]  EXCLUSIVE_RATIO_RST = 8'd10;
  localparam logic [9:0]  CALM_RATIO_RST      = 10'd100;
  localparam logic [7:0]  BUSY_RATIO_RST      = 8'd20;

  typedef enum logic [1:0] {
    CFG_MIN_SAMPLES     = 2'd0,
    CFG_EXCLUSIVE_RATIO = 2'd1,
    CFG_CALM_RATIO      = 2'd2,
    CFG_BUSY_RATIO      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_SH_ACQ = 2'd0,
    MODE_EX_ACQ = 2'd1,
    MODE_SH_REL = 2'd2,
    MODE_EX_REL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_WAIT      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_FREE_SLOT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_MULT,
    S_DECIDE,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic    load;
    logic    shacq;
    logic    shrel;
    logic    xacq;
    logic    xrel;
    logic    sum_start;
    logic    sum_step;
    logic    mult;
    logic    decide;
    logic    xfinal;
    logic    finish;
    status_t status;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  sh_ok;
    logic  rel_ok;
    logic  free_all;
    logic  any_flag;
    logic  sum_last;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

[rtl/core/arwl_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Lock controller
// Sequences one request at a time through the datapath and picks the status.
// ---------------------------------------------------------------------------
module arwl_ctrl
  import arwl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.mode)
          MODE_EX_ACQ: state_next = stat.free_all ? S_SUM : S_IDLE;
          MODE_EX_REL: state_next = stat.any_flag ? S_SUM : S_IDLE;
          default:     state_next = S_IDLE;
        endcase
      end
      S_SUM: begin
        if (stat.sum_last) begin
          state_next = S_MULT;
        end
      end
      S_MULT:   state_next = S_DECIDE;
      S_DECIDE: state_next = (stat.mode == MODE_EX_ACQ) ? S_FINAL : S_IDLE;
      S_FINAL:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ST_WAIT;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        case (stat.mode)
          MODE_SH_ACQ: begin
            cmd.shacq  = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = stat.sh_ok ? ST_GRANTED : ST_WAIT;
          end
          MODE_EX_ACQ: begin
            cmd.xacq      = 1'b1;
            cmd.sum_start = 1'b1;
            cmd.finish    = !stat.free_all;
            cmd.status    = ST_WAIT;
          end
          MODE_SH_REL: begin
            cmd.shrel  = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = stat.rel_ok ? ST_RELEASED : ST_FREE_SLOT;
          end
          default: begin
            cmd.xrel      = 1'b1;
            cmd.sum_start = 1'b1;
            cmd.finish    = !stat.any_flag;
            cmd.status    = ST_FREE_SLOT;
          end
        endcase
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
      end
      S_MULT: begin
        cmd.mult = 1'b1;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.finish = (stat.mode != MODE_EX_ACQ);
        cmd.status = ST_RELEASED;
      end
      S_FINAL: begin
        cmd.xfinal = 1'b1;
        cmd.finish = 1'b1;
        cmd.status = ST_GRANTED;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/arwl_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Lock datapath
// Slot counts, statistics, configuration and the resize decision.
// ---------------------------------------------------------------------------
module arwl_dp
  import arwl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        mode,
  input  logic [31:0]       requester_id,
  input  logic [2:0]        slot,
  input  logic              after_wait,
  output logic              done,
  output logic [1:0]        status,
  output logic [2:0]        granted_slot,
  output logic [3:0]        active_slots
);

  logic [WORD_W-1:0] slot_count      [SLOTS];
  logic [WORD_W-1:0] exclusive_stat  [SLOTS];
  logic [WORD_W-1:0] shared_stat     [SLOTS];
  logic [WORD_W-1:0] contention_stat [SLOTS];

  logic [CNT_W-1:0]  act;
  logic [WORD_W-1:0] rotation;

  logic [31:0] min_samples;
  logic [7:0]  exclusive_ratio;
  logic [9:0]  calm_ratio;
  logic [7:0]  busy_ratio;

  mode_t             mode_q;
  logic [WORD_W-1:0] rid_q;
  logic [SLOT_W-1:0] slot_q;
  logic              waited_q;

  logic [SLOT_W-1:0]      i;
  logic [SUM_W-1:0]       excl_sum;
  logic [SUM_W-1:0]       shr_sum;
  logic [WORD_W-1:0]      minc;
  logic [TOTAL_W-1:0]     total_q;
  logic [EXCL_PROD_W-1:0] excl_prod;
  logic [CALM_PROD_W-1:0] calm_prod;
  logic [BUSY_PROD_W-1:0] busy_prod;

  status_t           status_q;

  logic [SLOT_W-1:0] act_m1;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] st_addr;
  logic [WORD_W-1:0] rd_c;
  logic [SLOTS-1:0]  flag_vec;
  logic [SLOTS-1:0]  zero_vec;
  logic [SLOTS-1:0]  act_mask;
  logic              enough;
  logic              shrink;
  logic              grow;
  logic [CNT_W-1:0]  act_new;

  assign act_m1  = SLOT_W'(act - 1'b1);
  assign idx     = (rid_q[SLOT_W-1:0] + rotation[SLOT_W-1:0]) & act_m1;
  assign rd_addr = cmd.shacq ? idx : slot_q;
  assign st_addr = cmd.sum_step ? i : idx;
  assign rd_c    = slot_count[rd_addr];

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      flag_vec[j] = slot_count[j][WORD_W-1];
      zero_vec[j] = (slot_count[j] == '0);
      act_mask[j] = (CNT_W'(j) < act);
    end
  end

  always_comb begin
    enough  = (total_q >= TOTAL_W'(min_samples));
    shrink  = (excl_prod > EXCL_PROD_W'(total_q)) && (calm_prod < CALM_PROD_W'(total_q));
    grow    = (busy_prod > BUSY_PROD_W'(total_q));
    act_new = act;
    if (enough) begin
      if (shrink) begin
        if (act > CNT_W'(1)) begin
          act_new = act >> 1;
        end
      end else if (grow) begin
        if (act < CNT_W'(SLOTS)) begin
          act_new = (act << 1) > CNT_W'(SLOTS) ? CNT_W'(SLOTS) : act << 1;
        end
      end
    end
  end

  assign stat.mode     = mode_q;
  assign stat.sh_ok    = !rd_c[WORD_W-1] && (rd_c[WORD_W-2:0] != '1);
  assign stat.rel_ok   = !rd_c[WORD_W-1] && (rd_c != '0);
  assign stat.free_all = ((zero_vec & act_mask) == act_mask);
  assign stat.any_flag = |flag_vec;
  assign stat.sum_last = (i == act_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples     <= MIN_SAMPLES_RST;
      exclusive_ratio <= EXCLUSIVE_RATIO_RST;
      calm_ratio      <= CALM_RATIO_RST;
      busy_ratio      <= BUSY_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_SAMPLES:     min_samples     <= cfg_data;
        CFG_EXCLUSIVE_RATIO: exclusive_ratio <= cfg_data[7:0];
        CFG_CALM_RATIO:      calm_ratio      <= cfg_data[9:0];
        CFG_BUSY_RATIO:      busy_ratio      <= cfg_data[7:0];
        default:             min_samples     <= min_samples;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode_t'(mode);
      rid_q    <= requester_id;
      slot_q   <= slot;
      waited_q <= after_wait;
    end
    if (cmd.sum_start) begin
      i        <= '0;
      excl_sum <= '0;
      shr_sum  <= '0;
      minc     <= '1;
    end
    if (cmd.sum_step) begin
      i        <= i + 1'b1;
      excl_sum <= excl_sum + SUM_W'(exclusive_stat[i]);
      shr_sum  <= shr_sum + SUM_W'(shared_stat[st_addr]);
      if (contention_stat[st_addr] < minc) begin
        minc <= contention_stat[st_addr];
      end
    end
    if (cmd.mult) begin
      total_q   <= TOTAL_W'(excl_sum) + TOTAL_W'(shr_sum);
      excl_prod <= EXCL_PROD_W'(excl_sum) * EXCL_PROD_W'(exclusive_ratio);
      calm_prod <= CALM_PROD_W'(minc) * CALM_PROD_W'(calm_ratio);
      busy_prod <= BUSY_PROD_W'(minc) * BUSY_PROD_W'(busy_ratio);
    end
    if (cmd.finish) begin
      status_q     <= cmd.status;
      granted_slot <= (cmd.shacq && stat.sh_ok) ? 3'(idx) : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SLOTS; j++) begin
        slot_count[j]      <= '0;
        exclusive_stat[j]  <= '0;
        shared_stat[j]     <= '0;
        contention_stat[j] <= '0;
      end
      act      <= CNT_W'(SLOTS);
      rotation <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.shacq) begin
        rotation <= rotation + 1'b1;
        if (stat.sh_ok) begin
          slot_count[rd_addr]  <= rd_c + 1'b1;
          shared_stat[st_addr] <= sat_inc(shared_stat[st_addr]);
          if (waited_q) begin
            contention_stat[st_addr] <= sat_inc(contention_stat[st_addr]);
          end
        end
      end
      if (cmd.shrel && stat.rel_ok) begin
        slot_count[rd_addr] <= rd_c - 1'b1;
      end
      if (cmd.xacq && stat.free_all) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (act_mask[j]) begin
            slot_count[j] <= EXCL_MARK;
          end
        end
      end
      if (cmd.xrel) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (flag_vec[j]) begin
            slot_count[j] <= '0;
          end
        end
      end
      if (cmd.decide && (act_new != act)) begin
        act <= act_new;
        for (int j = 0; j < SLOTS; j++) begin
          exclusive_stat[j]  <= '0;
          shared_stat[j]     <= '0;
          contention_stat[j] <= '0;
        end
      end
      if (cmd.xfinal) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (act_mask[j]) begin
            slot_count[j]     <= slot_count[j] | EXCL_MARK;
            exclusive_stat[j] <= sat_inc(exclusive_stat[j]);
            if (waited_q) begin
              contention_stat[j] <= sat_inc(contention_stat[j]);
            end
          end
        end
      end
    end
  end

  assign status       = status_q;
  assign active_slots = 4'(act);

`ifndef SYNTH
  a_act_pow2: assert property (@(posedge clk) disable iff (rst) $onehot(act))
    else $error("Active slot count is not a power of two.");

  a_act_on_decide: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (act != $past(act))) |-> $past(cmd.decide))
    else $error("Active slot count changed outside a resize decision.");

  a_excl_owns_all: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.xfinal) && !$past(rst) |-> ((flag_vec & act_mask) == act_mask))
    else $error("Exclusive grant left an active slot unflagged.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result word strobe lasted more than one cycle.");
`endif

endmodule
`default_nettype wire

[rtl/core/adaptive_reader_writer_lock.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Adaptive reader-writer lock
// Try-acquire and release of a sharded reader-writer lock with resizing.
// ---------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result word
// appears on status, granted_slot and active_slots for exactly one cycle with
// done high, and must be captured then. Shared acquires, shared releases,
// refused exclusive acquires and exclusive releases with nothing to free give
// done from the execute state. An exclusive release that frees slots runs
// the statistics sum, the multiply and the resize decision; a granted
// exclusive acquire adds a final state that flags every active slot. The
// statistics sum visits one active slot per cycle. busy drops in the
// cycle done is high, so the next request can be taken then. Configuration
// writes take effect at once and should only be made while the lock is idle.
// ---------------------------------------------------------------------------
module adaptive_reader_writer_lock
  import arwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] requester_id,
  input  logic [2:0]  slot,
  input  logic        after_wait,
  output logic        done,
  output logic [1:0]  status,
  output logic [2:0]  granted_slot,
  output logic [3:0]  active_slots,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  arwl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  arwl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .requester_id (requester_id),
    .slot         (slot),
    .after_wait   (after_wait),
    .done         (done),
    .status       (status),
    .granted_slot (granted_slot),
    .active_slots (active_slots)
  );

endmodule
`default_nettype wire
